/* sv/lts_pkg.sv */
// ----------------------------------------------------------------------------
// lts_pkg
// Types and constants shared by the literal token scanner modules.
// ----------------------------------------------------------------------------
package lts_pkg;

    // command codes
    localparam logic [2:0] CMD_CONTINUE = 3'd0;
    localparam logic [2:0] CMD_STRING   = 3'd1;
    localparam logic [2:0] CMD_CHAR     = 3'd2;
    localparam logic [2:0] CMD_INTEGER  = 3'd3;
    localparam logic [2:0] CMD_NATURAL  = 3'd4;
    localparam logic [2:0] CMD_REAL     = 3'd5;

    // token kind codes
    localparam logic [1:0] KIND_STRING  = 2'd0;
    localparam logic [1:0] KIND_CHAR    = 2'd1;
    localparam logic [1:0] KIND_INTEGER = 2'd2;
    localparam logic [1:0] KIND_REAL    = 2'd3;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_READ      = 3'd1;
    localparam logic [2:0] ERR_PREMATURE = 3'd2;
    localparam logic [2:0] ERR_UNEXPECT  = 3'd3;
    localparam logic [2:0] ERR_ESCAPE    = 3'd4;
    localparam logic [2:0] ERR_EMPTY     = 3'd5;
    localparam logic [2:0] ERR_NO_QUOTE  = 3'd6;

    // characters
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPER_E = 8'h45;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LOWER_E = 8'h65;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_TILDE  = 8'h7E;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_STR,
        ST_CHR_OPEN,
        ST_CHR_BODY,
        ST_CHR_ESC,
        ST_CHR_CLOSE,
        ST_INT_SIGN,
        ST_NAT_SIGN,
        ST_INT_DIG1,
        ST_INT_DIGS,
        ST_INT_ESIGN,
        ST_INT_EDIG1,
        ST_INT_EDIGS,
        ST_REAL_SIGN,
        ST_REAL_LEAD,
        ST_REAL_FRAC1,
        ST_REAL_FRAC,
        ST_REAL_INT,
        ST_REAL_FRAC2,
        ST_REAL_EXP,
        ST_REAL_ESIGN,
        ST_REAL_EDIG1,
        ST_REAL_EDIGS
    } scan_state_t;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] char_code;
        logic       at_end;
        logic       read_fault;
    } lts_req_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_valid;
        logic       consumed;
        logic       token_done;
        logic [2:0] error_code;
        logic [1:0] token_kind;
    } lts_rsp_t;

    // classified item, as held in the queue
    typedef struct packed {
        logic        start;
        scan_state_t start_state;
        logic [7:0]  chr;
        logic        fault;
        logic        at_end;
        logic        have;
        logic        dig;
        logic        is_e;
        logic        plus;
        logic        minus;
        logic        dot;
        logic        quote;
        logic        bslash;
        logic        ltr_n;
        logic        ltr_t;
        logic        tilde;
        logic        under;
        logic        blank;
    } lts_entry_t;

endpackage

/* sv/lts_front.sv */
// ----------------------------------------------------------------------------
// lts_front
// Accepts input items and classifies the command and character for the queue.
// ----------------------------------------------------------------------------
module lts_front
(
    input  logic                  req_valid,
    output logic                  req_stall,
    input  lts_pkg::lts_req_t     req,
    input  logic                  queue_full,
    output logic                  push,
    output lts_pkg::lts_entry_t   entry
);

    logic       have;
    logic [7:0] c;

    assign req_stall = queue_full;
    assign push      = req_valid && !queue_full;
    assign c         = req.char_code;
    assign have      = !req.at_end && !req.read_fault;

    always_comb
    begin
        entry.start       = 1'b1;
        entry.start_state = lts_pkg::ST_IDLE;
        case (req.command)
            lts_pkg::CMD_STRING:  entry.start_state = lts_pkg::ST_STR;
            lts_pkg::CMD_CHAR:    entry.start_state = lts_pkg::ST_CHR_OPEN;
            lts_pkg::CMD_INTEGER: entry.start_state = lts_pkg::ST_INT_SIGN;
            lts_pkg::CMD_NATURAL: entry.start_state = lts_pkg::ST_NAT_SIGN;
            lts_pkg::CMD_REAL:    entry.start_state = lts_pkg::ST_REAL_SIGN;
            default:              entry.start       = 1'b0;   // continue, unused codes
        endcase

        entry.chr    = c;
        entry.fault  = req.read_fault;
        entry.at_end = req.at_end;
        entry.have   = have;
        entry.dig    = have && (c inside {[lts_pkg::CH_ZERO:lts_pkg::CH_NINE]});
        entry.is_e   = have && (c inside {lts_pkg::CH_LOWER_E, lts_pkg::CH_UPPER_E});
        entry.plus   = have && (c == lts_pkg::CH_PLUS);
        entry.minus  = have && (c == lts_pkg::CH_MINUS);
        entry.dot    = have && (c == lts_pkg::CH_DOT);
        entry.quote  = have && (c == lts_pkg::CH_QUOTE);
        entry.bslash = have && (c == lts_pkg::CH_BSLASH);
        entry.ltr_n  = have && (c == lts_pkg::CH_LOWER_N);
        entry.ltr_t  = have && (c == lts_pkg::CH_LOWER_T);
        entry.tilde  = have && (c == lts_pkg::CH_TILDE);
        entry.under  = have && (c == lts_pkg::CH_UNDER);
        entry.blank  = have && (c inside {lts_pkg::CH_SPACE, lts_pkg::CH_TAB,
                                          lts_pkg::CH_LF, lts_pkg::CH_CR});
    end

endmodule

/* sv/lts_fifo.sv */
// ----------------------------------------------------------------------------
// lts_fifo
// Short queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module lts_fifo
#(
    parameter int DEPTH = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  lts_pkg::lts_entry_t   din,
    output logic                  full,
    input  logic                  pop,
    output lts_pkg::lts_entry_t   dout,
    output logic                  not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lts_pkg::lts_entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign dout      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

/* sv/lts_back.sv */
// ----------------------------------------------------------------------------
// lts_back
// Scan state machine: steps one classified item and registers the result.
// ----------------------------------------------------------------------------
module lts_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_ready,
    input  lts_pkg::lts_entry_t   item,
    output logic                  pop,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output lts_pkg::lts_rsp_t     rsp
);

    lts_pkg::scan_state_t state_reg, state_next;
    lts_pkg::lts_rsp_t    rsp_reg, rsp_next;
    logic                 valid_reg, valid_next;

    assign pop       = item_ready && (!valid_reg || !rsp_stall);
    assign rsp_valid = valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        lts_pkg::scan_state_t st;
        lts_pkg::scan_state_t nxt;
        lts_pkg::lts_rsp_t    r;
        logic                 handled;
        logic [2:0]           miss;

        st      = item.start ? item.start_state : state_reg;
        nxt     = st;
        r       = '0;
        handled = 1'b0;
        miss    = item.fault ? lts_pkg::ERR_READ :
                  (item.at_end ? lts_pkg::ERR_PREMATURE : lts_pkg::ERR_UNEXPECT);

        case (st)
            lts_pkg::ST_CHR_OPEN, lts_pkg::ST_CHR_BODY, lts_pkg::ST_CHR_ESC,
            lts_pkg::ST_CHR_CLOSE:
                r.token_kind = lts_pkg::KIND_CHAR;
            lts_pkg::ST_INT_SIGN, lts_pkg::ST_NAT_SIGN, lts_pkg::ST_INT_DIG1,
            lts_pkg::ST_INT_DIGS, lts_pkg::ST_INT_ESIGN, lts_pkg::ST_INT_EDIG1,
            lts_pkg::ST_INT_EDIGS:
                r.token_kind = lts_pkg::KIND_INTEGER;
            lts_pkg::ST_REAL_SIGN, lts_pkg::ST_REAL_LEAD, lts_pkg::ST_REAL_FRAC1,
            lts_pkg::ST_REAL_FRAC, lts_pkg::ST_REAL_INT, lts_pkg::ST_REAL_FRAC2,
            lts_pkg::ST_REAL_EXP, lts_pkg::ST_REAL_ESIGN, lts_pkg::ST_REAL_EDIG1,
            lts_pkg::ST_REAL_EDIGS:
                r.token_kind = lts_pkg::KIND_REAL;
            default:
                r.token_kind = lts_pkg::KIND_STRING;
        endcase

        // optional leading sign; otherwise fall through to the next phase
        case (st)
            lts_pkg::ST_INT_SIGN,
            lts_pkg::ST_NAT_SIGN:
            begin
                if (item.plus || (st == lts_pkg::ST_INT_SIGN && item.minus))
                begin
                    r.out_char = item.chr; r.out_valid = 1'b1; r.consumed = 1'b1;
                    nxt = lts_pkg::ST_INT_DIG1;
                    handled = 1'b1;
                end
                else
                begin
                    st = lts_pkg::ST_INT_DIG1;
                end
            end
            lts_pkg::ST_REAL_SIGN:
            begin
                if (item.plus || item.minus)
                begin
                    r.out_char = item.chr; r.out_valid = 1'b1; r.consumed = 1'b1;
                    nxt = lts_pkg::ST_REAL_LEAD;
                    handled = 1'b1;
                end
                else
                begin
                    st = lts_pkg::ST_REAL_LEAD;
                end
            end
            default: ;
        endcase

        // mantissa phases of a real that fall through to the exponent
        if (!handled)
        begin
            case (st)
                lts_pkg::ST_REAL_LEAD:
                begin
                    if (item.dot || item.dig)
                    begin
                        r.out_char = item.chr; r.out_valid = 1'b1; r.consumed = 1'b1;
                        nxt = item.dot ? lts_pkg::ST_REAL_FRAC1 : lts_pkg::ST_REAL_INT;
                        handled = 1'b1;
                    end
                    else
                    begin
                        st = lts_pkg::ST_REAL_EXP;
                    end
                end
                lts_pkg::ST_REAL_FRAC,
                lts_pkg::ST_REAL_FRAC2:
                begin
                    if (item.dig)
                    begin
                        r.out_char = item.chr; r.out_valid = 1'b1; r.consumed = 1'b1;
                        handled = 1'b1;
                    end
                    else
                    begin
                        st = lts_pkg::ST_REAL_EXP;
                    end
                end
                lts_pkg::ST_REAL_INT:
                begin
                    if (item.dig || item.dot)
                    begin
                        r.out_char = item.chr; r.out_valid = 1'b1; r.consumed = 1'b1;
                        if (item.dot)
                        begin
                            nxt = lts_pkg::ST_REAL_FRAC2;
                        end
                        handled = 1'b1;
                    end
                    else
                    begin
                        st = lts_pkg::ST_REAL_EXP;
                    end
                end
                default: ;
            endcase
        end

        // exponent mark of a real, optional exponent sign
        if (!handled)
        begin
            case (st)
                lts_pkg::ST_REAL_EXP:
                begin
                    if (item.is_e)
                    begin
                        r.out_char = item.chr; r.out_valid = 1'b1; r.consumed = 1'b1;
                        nxt = lts_pkg::ST_REAL_ESIGN;
                    end
                    else
                    begin
                        r.token_done = 1'b1;
                        nxt = lts_pkg::ST_IDLE;
                    end
                    handled = 1'b1;
                end
                lts_pkg::ST_REAL_ESIGN:
                begin
                    if (item.plus || item.minus)
                    begin
                        r.out_char = item.chr; r.out_valid = 1'b1; r.consumed = 1'b1;
                        nxt = lts_pkg::ST_REAL_EDIG1;
                        handled = 1'b1;
                    end
                    else
                    begin
                        st = lts_pkg::ST_REAL_EDIG1;
                    end
                end
                lts_pkg::ST_INT_ESIGN:
                begin
                    if (item.plus)
                    begin
                        r.out_char = item.chr; r.out_valid = 1'b1; r.consumed = 1'b1;
                        nxt = lts_pkg::ST_INT_EDIG1;
                        handled = 1'b1;
                    end
                    else
                    begin
                        st = lts_pkg::ST_INT_EDIG1;
                    end
                end
                default: ;
            endcase
        end

        if (!handled)
        begin
            case (st)
                lts_pkg::ST_STR:
                begin
                    if (item.fault)
                    begin
                        r.token_done = 1'b1; r.error_code = lts_pkg::ERR_READ;
                        nxt = lts_pkg::ST_IDLE;
                    end
                    else if (item.at_end || item.blank)
                    begin
                        r.token_done = 1'b1;
                        nxt = lts_pkg::ST_IDLE;
                    end
                    else
                    begin
                        r.out_valid = 1'b1; r.consumed = 1'b1;
                        r.out_char = item.tilde ? lts_pkg::CH_TAB :
                                     (item.under ? lts_pkg::CH_SPACE : item.chr);
                    end
                end
                lts_pkg::ST_CHR_OPEN:
                begin
                    if (item.quote)
                    begin
                        r.consumed = 1'b1;
                        nxt = lts_pkg::ST_CHR_BODY;
                    end
                    else
                    begin
                        r.token_done = 1'b1; r.error_code = miss;
                        nxt = lts_pkg::ST_IDLE;
                    end
                end
                lts_pkg::ST_CHR_BODY:
                begin
                    if (item.fault || item.at_end)
                    begin
                        r.token_done = 1'b1;
                        r.error_code = item.fault ? lts_pkg::ERR_READ : lts_pkg::ERR_EMPTY;
                        nxt = lts_pkg::ST_IDLE;
                    end
                    else if (item.bslash)
                    begin
                        r.consumed = 1'b1;
                        nxt = lts_pkg::ST_CHR_ESC;
                    end
                    else
                    begin
                        r.out_char = item.chr; r.out_valid = 1'b1; r.consumed = 1'b1;
                        nxt = lts_pkg::ST_CHR_CLOSE;
                    end
                end
                lts_pkg::ST_CHR_ESC:
                begin
                    if (item.quote || item.ltr_n || item.ltr_t || item.bslash)
                    begin
                        r.out_valid = 1'b1; r.consumed = 1'b1;
                        r.out_char = item.ltr_n ? lts_pkg::CH_LF :
                                     (item.ltr_t ? lts_pkg::CH_TAB : item.chr);
                        nxt = lts_pkg::ST_CHR_CLOSE;
                    end
                    else
                    begin
                        r.token_done = 1'b1;
                        r.error_code = item.fault ? lts_pkg::ERR_READ :
                                       (item.at_end ? lts_pkg::ERR_PREMATURE :
                                        lts_pkg::ERR_ESCAPE);
                        nxt = lts_pkg::ST_IDLE;
                    end
                end
                lts_pkg::ST_CHR_CLOSE:
                begin
                    r.token_done = 1'b1;
                    nxt = lts_pkg::ST_IDLE;
                    if (item.quote)
                    begin
                        r.consumed = 1'b1;
                    end
                    else
                    begin
                        r.error_code = lts_pkg::ERR_NO_QUOTE;
                    end
                end
                lts_pkg::ST_INT_DIG1,
                lts_pkg::ST_INT_EDIG1,
                lts_pkg::ST_REAL_FRAC1,
                lts_pkg::ST_REAL_EDIG1:
                begin
                    if (item.dig)
                    begin
                        r.out_char = item.chr; r.out_valid = 1'b1; r.consumed = 1'b1;
                        case (st)
                            lts_pkg::ST_INT_DIG1:   nxt = lts_pkg::ST_INT_DIGS;
                            lts_pkg::ST_INT_EDIG1:  nxt = lts_pkg::ST_INT_EDIGS;
                            lts_pkg::ST_REAL_FRAC1: nxt = lts_pkg::ST_REAL_FRAC;
                            default:                nxt = lts_pkg::ST_REAL_EDIGS;
                        endcase
                    end
                    else
                    begin
                        r.token_done = 1'b1; r.error_code = miss;
                        nxt = lts_pkg::ST_IDLE;
                    end
                end
                lts_pkg::ST_INT_DIGS:
                begin
                    if (item.dig || item.is_e)
                    begin
                        r.out_char = item.chr; r.out_valid = 1'b1; r.consumed = 1'b1;
                        if (item.is_e)
                        begin
                            nxt = lts_pkg::ST_INT_ESIGN;
                        end
                    end
                    else
                    begin
                        r.token_done = 1'b1;
                        nxt = lts_pkg::ST_IDLE;
                    end
                end
                lts_pkg::ST_INT_EDIGS,
                lts_pkg::ST_REAL_EDIGS:
                begin
                    if (item.dig)
                    begin
                        r.out_char = item.chr; r.out_valid = 1'b1; r.consumed = 1'b1;
                    end
                    else
                    begin
                        r.token_done = 1'b1;
                        nxt = lts_pkg::ST_IDLE;
                    end
                end
                default:
                begin
                    nxt = lts_pkg::ST_IDLE;
                end
            endcase
        end

        state_next = pop ? nxt : state_reg;
        rsp_next   = pop ? r : rsp_reg;
        valid_next = pop ? 1'b1 : (valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lts_pkg::ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

endmodule

/* sv/literal_token_scanner_core.sv */
// Path: an accepted item is written into the queue, then the back part's scan step registers its result.
// Throughput: one item per cycle while the output does not stall, set by the scan state step in the back part.
// The queue of QUEUE_DEPTH entries absorbs output stalls; input stalls only when it is full.
// Reset: asynchronous, clears the scan state to idle, empties the queue, drops any result.
// ----------------------------------------------------------------------------
// literal_token_scanner_core
// Literal token scanner: classifying front, item queue, scanning back part.
// ----------------------------------------------------------------------------
module literal_token_scanner_core
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  lts_pkg::lts_req_t   req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output lts_pkg::lts_rsp_t   rsp
);

    lts_pkg::lts_entry_t push_entry;
    lts_pkg::lts_entry_t head_entry;
    logic                push;
    logic                pop;
    logic                queue_full;
    logic                queue_not_empty;

    lts_front u_front
    (
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .queue_full (queue_full),
        .push       (push),
        .entry      (push_entry)
    );

    lts_fifo
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .din       (push_entry),
        .full      (queue_full),
        .pop       (pop),
        .dout      (head_entry),
        .not_empty (queue_not_empty)
    );

    lts_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_ready (queue_not_empty),
        .item       (head_entry),
        .pop        (pop),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp)
    );

endmodule
